// ----- src/dcw_pkg.sv -----
// Shared constants, register codes and types of the digit square crop window block.
`default_nettype none

package dcw_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MIN_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL_MIN_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN     = 3'd5;

    localparam logic [11:0] RST_IMAGE_WIDTH     = 12'd2048;
    localparam logic [11:0] RST_IMAGE_HEIGHT    = 12'd2048;
    localparam logic [7:0]  RST_BLACK_THRESHOLD = 8'd128;
    localparam logic [11:0] RST_ROW_MIN_COUNT   = 12'd5;
    localparam logic [11:0] RST_COL_MIN_COUNT   = 12'd5;
    localparam logic [9:0]  RST_EDGE_MARGIN     = 10'd100;

    // result queue depth, covers the report pipeline at full rate
    localparam int RES_DEPTH = 8;

    typedef struct packed {
        logic valid;
        logic col_hit;
        logic row_hit;
        logic restart;
        logic frame_end;
    } t_judge;

    typedef struct packed {
        logic               box_found;
        logic [11:0]        box_left;
        logic [10:0]        box_right;
        logic [11:0]        box_top;
        logic [10:0]        box_bottom;
        logic signed [11:0] crop_left;
        logic signed [11:0] crop_top;
        logic [11:0]        crop_size;
    } t_result;

    // width of internal size and count values
    function automatic int value_w(input int max_w, input int max_h);
        int a;
        int b;
        int r;
        a = $clog2(max_w + 1);
        b = $clog2(max_h + 1);
        r = 12;
        if (a > r) r = a;
        if (b > r) r = b;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/dcw_if.sv -----
// Handshake interfaces for the pixel and result channels.
`default_nettype none

interface dcw_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface dcw_res_if;
    logic               valid;
    logic               ready;
    logic               box_found;
    logic [11:0]        box_left;
    logic [10:0]        box_right;
    logic [11:0]        box_top;
    logic [10:0]        box_bottom;
    logic signed [11:0] crop_left;
    logic signed [11:0] crop_top;
    logic [11:0]        crop_size;

    modport source (output valid, output box_found, output box_left, output box_right,
                    output box_top, output box_bottom, output crop_left, output crop_top,
                    output crop_size, input ready);
    modport sink   (input valid, input box_found, input box_left, input box_right,
                    input box_top, input box_bottom, input crop_left, input crop_top,
                    input crop_size, output ready);
endinterface

`default_nettype wire

// ----- src/dcw_profile.sv -----
// Raster position, row count and column count memory with read-modify-write and forwarding.
`default_nettype none

module dcw_profile #(
    parameter int MAX_WIDTH  = dcw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcw_pkg::DEF_MAX_HEIGHT,
    parameter int VW         = dcw_pkg::value_w(MAX_WIDTH, MAX_HEIGHT),
    parameter int XW         = $clog2(MAX_WIDTH),
    parameter int YW         = $clog2(MAX_HEIGHT)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_pixel,
    input  wire logic          i_frame_start,
    input  wire logic [VW-1:0] i_width,
    input  wire logic [VW-1:0] i_height,
    input  wire logic [7:0]    i_threshold,
    input  wire logic [VW-1:0] i_margin,
    input  wire logic [VW-1:0] i_row_min,
    input  wire logic [VW-1:0] i_col_min,
    output logic               o_frame_end,
    output dcw_pkg::t_judge    o_judge,
    output logic [XW-1:0]      o_x,
    output logic [YW-1:0]      o_y,
    output logic [VW-1:0]      o_init_w,
    output logic [VW-1:0]      o_init_h
);

    localparam int CW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_WIDTH + 1);
    localparam int RST_W_INT = int'(dcw_pkg::RST_IMAGE_WIDTH);
    localparam int RST_H_INT = int'(dcw_pkg::RST_IMAGE_HEIGHT);
    localparam logic [VW-1:0] RST_EFF_W = (RST_W_INT == 0) ? VW'(1) :
                                          (RST_W_INT > MAX_WIDTH) ? VW'(MAX_WIDTH) : VW'(RST_W_INT);
    localparam logic [VW-1:0] RST_EFF_H = (RST_H_INT == 0) ? VW'(1) :
                                          (RST_H_INT > MAX_HEIGHT) ? VW'(MAX_HEIGHT) : VW'(RST_H_INT);

    // position and row state
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic [RW-1:0] r_row_cnt;
    logic          r_init_pend;
    logic [VW-1:0] r_init_w;
    logic [VW-1:0] r_init_h;

    // column count memory
    logic [CW-1:0] mem_cnt [MAX_WIDTH];
    logic [CW-1:0] r_mem_q;

    // stage 1
    logic          r_s1_valid;
    logic [XW-1:0] r_s1_x;
    logic [YW-1:0] r_s1_y;
    logic          r_s1_dark;
    logic [RW-1:0] r_s1_row_cnt;
    logic          r_s1_last_col;
    logic          r_s1_last_row;
    logic          r_s1_restart;
    logic [VW-1:0] r_s1_init_w;
    logic [VW-1:0] r_s1_init_h;
    logic          r_s1_fwd_hit;
    logic [CW-1:0] r_s1_fwd;

    // stage 2
    dcw_pkg::t_judge r_judge;
    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [VW-1:0]   r_init_w2;
    logic [VW-1:0]   r_init_h2;

    logic [XW-1:0] x0;
    logic [YW-1:0] y0;
    logic          last_col0;
    logic          last_row0;
    logic          dark0;
    logic [RW-1:0] row_cnt0;
    logic          restart0;
    logic [VW-1:0] init_w0;
    logic [VW-1:0] init_h0;

    logic [CW-1:0] rd1;
    logic [CW-1:0] total1;
    logic [VW-1:0] x1v;
    logic [VW-1:0] y1v;
    logic [VW:0]   x_far1;
    logic [VW:0]   y_far1;
    logic          col_hit1;
    logic          row_hit1;

    always_comb begin
        x0        = i_frame_start ? '0 : r_col;
        y0        = i_frame_start ? '0 : r_row;
        last_col0 = VW'(x0) >= (i_width - VW'(1));
        last_row0 = VW'(y0) >= (i_height - VW'(1));
        dark0     = i_pixel < i_threshold;
        row_cnt0  = (i_frame_start ? '0 : r_row_cnt) + RW'(dark0);
        restart0  = i_frame_start || r_init_pend;
        init_w0   = i_frame_start ? i_width : r_init_w;
        init_h0   = i_frame_start ? i_height : r_init_h;
    end

    assign o_frame_end = last_col0 && last_row0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_row_cnt   <= '0;
            r_init_pend <= 1'b1;
            r_init_w    <= RST_EFF_W;
            r_init_h    <= RST_EFF_H;
        end else if (i_accept) begin
            r_init_pend <= o_frame_end;
            if (o_frame_end) begin
                r_init_w <= i_width;
                r_init_h <= i_height;
            end
            if (last_col0) begin
                r_col     <= '0;
                r_row_cnt <= '0;
                r_row     <= last_row0 ? '0 : y0 + YW'(1);
            end else begin
                r_col     <= x0 + XW'(1);
                r_row_cnt <= row_cnt0;
                r_row     <= y0;
            end
        end
    end

    // stage 1: add this pixel to the column total, judge row and column
    always_comb begin
        rd1      = r_s1_fwd_hit ? r_s1_fwd : r_mem_q;
        total1   = ((r_s1_y == '0) ? '0 : rd1) + CW'(r_s1_dark);
        x1v      = VW'(r_s1_x);
        y1v      = VW'(r_s1_y);
        x_far1   = {1'b0, x1v} + {1'b0, i_margin};
        y_far1   = {1'b0, y1v} + {1'b0, i_margin};
        col_hit1 = r_s1_last_row && (x1v >= i_margin) && (x_far1 < {1'b0, i_width})
                   && (VW'(total1) > i_col_min);
        row_hit1 = r_s1_last_col && (y1v >= i_margin) && (y_far1 < {1'b0, i_height})
                   && (VW'(r_s1_row_cnt) > i_row_min);
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_cnt[r_s1_x] <= total1;
        end
        if (i_accept) begin
            r_mem_q <= mem_cnt[x0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_x        <= x0;
            r_s1_y        <= y0;
            r_s1_dark     <= dark0;
            r_s1_row_cnt  <= row_cnt0;
            r_s1_last_col <= last_col0;
            r_s1_last_row <= last_row0;
            r_s1_restart  <= restart0;
            r_s1_init_w   <= init_w0;
            r_s1_init_h   <= init_h0;
            // the write in flight this edge is missed by the memory read
            r_s1_fwd_hit  <= r_s1_valid && (r_s1_x == x0);
            r_s1_fwd      <= total1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_judge.valid <= 1'b0;
        end else begin
            r_judge.valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_judge.col_hit   <= col_hit1;
        r_judge.row_hit   <= row_hit1;
        r_judge.restart   <= r_s1_restart;
        r_judge.frame_end <= r_s1_last_col && r_s1_last_row;
        r_x               <= r_s1_x;
        r_y               <= r_s1_y;
        r_init_w2         <= r_s1_init_w;
        r_init_h2         <= r_s1_init_h;
    end

    assign o_judge  = r_judge;
    assign o_x      = r_x;
    assign o_y      = r_y;
    assign o_init_w = r_init_w2;
    assign o_init_h = r_init_h2;

endmodule

`default_nettype wire

// ----- src/dcw_box.sv -----
// Bounding box trackers and the crop window pipeline.
`default_nettype none

module dcw_box #(
    parameter int MAX_WIDTH  = dcw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcw_pkg::DEF_MAX_HEIGHT,
    parameter int VW         = dcw_pkg::value_w(MAX_WIDTH, MAX_HEIGHT),
    parameter int XW         = $clog2(MAX_WIDTH),
    parameter int YW         = $clog2(MAX_HEIGHT)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dcw_pkg::t_judge i_judge,
    input  wire logic [XW-1:0]   i_x,
    input  wire logic [YW-1:0]   i_y,
    input  wire logic [VW-1:0]   i_init_w,
    input  wire logic [VW-1:0]   i_init_h,
    input  wire logic [VW-1:0]   i_width,
    input  wire logic [VW-1:0]   i_height,
    output logic                 o_res_valid,
    output dcw_pkg::t_result     o_res
);

    localparam int SW  = VW + 2;
    localparam int VW1 = VW + 1;

    // trackers
    logic [VW-1:0] r_lc;
    logic [XW-1:0] r_gc;
    logic [VW-1:0] r_lr;
    logic [YW-1:0] r_gr;

    logic [VW-1:0] lc_base;
    logic [XW-1:0] gc_base;
    logic [VW-1:0] lr_base;
    logic [YW-1:0] gr_base;
    logic [VW-1:0] lc_n;
    logic [XW-1:0] gc_n;
    logic [VW-1:0] lr_n;
    logic [YW-1:0] gr_n;

    // snapshot at frame end
    logic          r_a_valid;
    logic [VW-1:0] r_a_lc;
    logic [XW-1:0] r_a_gc;
    logic [VW-1:0] r_a_lr;
    logic [YW-1:0] r_a_gr;

    logic             found_b;
    logic [VW-1:0]    gc_b;
    logic [VW-1:0]    gr_b;
    dcw_pkg::t_result res_b;

    logic             r_b_valid;
    logic             r_b_found;
    logic [VW-1:0]    r_b_dw;
    logic [VW-1:0]    r_b_dh;
    logic [VW1-1:0]   r_b_sumx;
    logic [VW1-1:0]   r_b_sumy;
    dcw_pkg::t_result r_b_res;

    logic [VW-1:0]    size_c;

    logic             r_c_valid;
    logic             r_c_found;
    logic [VW-1:0]    r_c_size;
    logic [VW-1:0]    r_c_half;
    logic [VW-1:0]    r_c_cx;
    logic [VW-1:0]    r_c_cy;
    dcw_pkg::t_result r_c_res;

    logic                 r_d_valid;
    logic                 r_d_found;
    logic [VW-1:0]        r_d_size;
    logic signed [SW-1:0] r_d_ax;
    logic signed [SW-1:0] r_d_ay;
    logic signed [SW-1:0] r_d_wl;
    logic signed [SW-1:0] r_d_hl;
    dcw_pkg::t_result     r_d_res;

    logic signed [SW-1:0] ax1;
    logic signed [SW-1:0] ay1;
    logic signed [SW-1:0] endx;
    logic signed [SW-1:0] endy;
    logic signed [SW-1:0] left_e;
    logic signed [SW-1:0] top_e;

    always_comb begin
        lc_base = i_judge.restart ? i_init_w : r_lc;
        gc_base = i_judge.restart ? '0 : r_gc;
        lr_base = i_judge.restart ? i_init_h : r_lr;
        gr_base = i_judge.restart ? '0 : r_gr;
        lc_n = (i_judge.col_hit && (VW'(i_x) < lc_base)) ? VW'(i_x) : lc_base;
        gc_n = (i_judge.col_hit && (i_x > gc_base)) ? i_x : gc_base;
        lr_n = (i_judge.row_hit && (VW'(i_y) < lr_base)) ? VW'(i_y) : lr_base;
        gr_n = (i_judge.row_hit && (i_y > gr_base)) ? i_y : gr_base;
    end

    always_ff @(posedge i_clk) begin
        if (i_judge.valid) begin
            r_lc <= lc_n;
            r_gc <= gc_n;
            r_lr <= lr_n;
            r_gr <= gr_n;
        end
        r_a_lc <= lc_n;
        r_a_gc <= gc_n;
        r_a_lr <= lr_n;
        r_a_gr <= gr_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_judge.valid && i_judge.frame_end;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // report stage b: box edges, extents and edge sums
    always_comb begin
        gc_b    = VW'(r_a_gc);
        gr_b    = VW'(r_a_gr);
        found_b = (gc_b >= r_a_lc) && (gr_b >= r_a_lr);
        res_b            = '0;
        res_b.box_found  = found_b;
        res_b.box_left   = r_a_lc[11:0];
        res_b.box_right  = gc_b[10:0];
        res_b.box_top    = r_a_lr[11:0];
        res_b.box_bottom = gr_b[10:0];
    end

    always_ff @(posedge i_clk) begin
        r_b_found <= found_b;
        r_b_dw    <= gc_b - r_a_lc + VW'(1);
        r_b_dh    <= gr_b - r_a_lr + VW'(1);
        r_b_sumx  <= VW1'(r_a_lc) + VW1'(gc_b);
        r_b_sumy  <= VW1'(r_a_lr) + VW1'(gr_b);
        r_b_res   <= res_b;
    end

    // report stage c: window side and centre
    assign size_c = (r_b_dw > r_b_dh) ? r_b_dw : r_b_dh;

    always_ff @(posedge i_clk) begin
        r_c_found <= r_b_found;
        r_c_size  <= size_c;
        r_c_half  <= size_c >> 1;
        r_c_cx    <= r_b_sumx[VW:1];
        r_c_cy    <= r_b_sumy[VW:1];
        r_c_res   <= r_b_res;
    end

    // report stage d: raw window start and the start that ends on the last pixel
    always_ff @(posedge i_clk) begin
        r_d_found <= r_c_found;
        r_d_size  <= r_c_size;
        r_d_ax    <= $signed(SW'(r_c_cx)) - $signed(SW'(r_c_half));
        r_d_ay    <= $signed(SW'(r_c_cy)) - $signed(SW'(r_c_half));
        r_d_wl    <= $signed(SW'(i_width)) - $signed(SW'(r_c_size));
        r_d_hl    <= $signed(SW'(i_height)) - $signed(SW'(r_c_size));
        r_d_res   <= r_c_res;
    end

    // report stage e: shift right into the image, then left if it sticks out
    always_comb begin
        ax1    = r_d_ax[SW-1] ? '0 : r_d_ax;
        ay1    = r_d_ay[SW-1] ? '0 : r_d_ay;
        endx   = ax1 + $signed(SW'(r_d_size));
        endy   = ay1 + $signed(SW'(r_d_size));
        left_e = (endx > $signed(SW'(i_width))) ? r_d_wl : ax1;
        top_e  = (endy > $signed(SW'(i_height))) ? r_d_hl : ay1;
        o_res  = r_d_res;
        if (r_d_found) begin
            o_res.crop_left = left_e[11:0];
            o_res.crop_top  = top_e[11:0];
            o_res.crop_size = r_d_size[11:0];
        end
    end

    assign o_res_valid = r_d_valid;

endmodule

`default_nettype wire

// ----- src/dcw_out_q.sv -----
// Result queue between the report pipeline and the result channel.
`default_nettype none

module dcw_out_q (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dcw_pkg::t_result i_data,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output dcw_pkg::t_result      o_data
);

    localparam int AW = $clog2(dcw_pkg::RES_DEPTH);
    localparam int NW = $clog2(dcw_pkg::RES_DEPTH + 1);

    dcw_pkg::t_result r_slot [dcw_pkg::RES_DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [NW-1:0]    r_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + AW'(1);
            end
            unique case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/digit_square_crop_window_top.sv -----
// Top level of the digit square crop window block: projection profiles to a square crop.
//
// Pixels enter on i_pix (valid/ready, one transaction per grey pixel in raster order,
// frame_start marks pixel (0,0)). A pixel is dark when below the black threshold; dark
// pixels are counted per row and, in a column count memory, per column. On the last
// pixel of a frame one transaction leaves on o_res with the bounding box of the rows and
// columns whose counts pass the minimums inside the edge margin, and a centered square
// crop window shifted back into the image. Other pixels produce nothing.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data); write it only
// while no frame result is outstanding.
// Throughput: one pixel per cycle while i_pix.ready is high. The column memory is read
// at accept and written in the next cycle; a same-column write in that cycle is
// forwarded around the memory. The result passes the memory read, judge and trackers,
// then four report stages, then waits in an 8-entry queue.
// Stall: i_pix.ready drops only when 8 results are accepted but not yet taken, so a
// stalled receiver holds the input back without losing results.
// Reset: synchronous, active low; configuration returns to its reset values, position
// to (0,0), the queue empties. The column memory needs no clearing pass since row 0 of
// every frame rewrites it.
`default_nettype none

module digit_square_crop_window_top #(
    parameter int MAX_WIDTH  = dcw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dcw_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    dcw_pix_if.sink                             i_pix,
    dcw_res_if.source                           o_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [dcw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int VW = dcw_pkg::value_w(MAX_WIDTH, MAX_HEIGHT);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int PW = $clog2(dcw_pkg::RES_DEPTH + 1);

    // configuration registers
    logic [11:0] r_image_width;
    logic [11:0] r_image_height;
    logic [7:0]  r_black_thr;
    logic [11:0] r_row_min;
    logic [11:0] r_col_min;
    logic [9:0]  r_margin;

    logic [VW-1:0] w_eff;
    logic [VW-1:0] h_eff;

    logic          accept;
    logic          frame_end;
    logic          pop;
    logic [PW-1:0] r_pend;

    dcw_pkg::t_judge  judge;
    logic [XW-1:0]    judge_x;
    logic [YW-1:0]    judge_y;
    logic [VW-1:0]    init_w;
    logic [VW-1:0]    init_h;
    logic             rep_valid;
    dcw_pkg::t_result rep;
    dcw_pkg::t_result q_data;
    logic             q_valid;

    // take register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= dcw_pkg::RST_IMAGE_WIDTH;
            r_image_height <= dcw_pkg::RST_IMAGE_HEIGHT;
            r_black_thr    <= dcw_pkg::RST_BLACK_THRESHOLD;
            r_row_min      <= dcw_pkg::RST_ROW_MIN_COUNT;
            r_col_min      <= dcw_pkg::RST_COL_MIN_COUNT;
            r_margin       <= dcw_pkg::RST_EDGE_MARGIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dcw_pkg::REG_IMAGE_WIDTH:     r_image_width  <= i_cfg_data;
                dcw_pkg::REG_IMAGE_HEIGHT:    r_image_height <= i_cfg_data;
                dcw_pkg::REG_BLACK_THRESHOLD: r_black_thr    <= i_cfg_data[7:0];
                dcw_pkg::REG_ROW_MIN_COUNT:   r_row_min      <= i_cfg_data;
                dcw_pkg::REG_COL_MIN_COUNT:   r_col_min      <= i_cfg_data;
                dcw_pkg::REG_EDGE_MARGIN:     r_margin       <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // a zero size acts as one, oversize saturates to MAX_WIDTH or MAX_HEIGHT
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = VW'(1);
        end else if (VW'(r_image_width) > VW'(MAX_WIDTH)) begin
            w_eff = VW'(MAX_WIDTH);
        end else begin
            w_eff = VW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = VW'(1);
        end else if (VW'(r_image_height) > VW'(MAX_HEIGHT)) begin
            h_eff = VW'(MAX_HEIGHT);
        end else begin
            h_eff = VW'(r_image_height);
        end
    end

    // hold input back once every queue slot is promised to a result
    assign i_pix.ready = (r_pend != PW'(dcw_pkg::RES_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;
    assign pop         = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            unique case ({accept && frame_end, pop})
                2'b10:   r_pend <= r_pend + PW'(1);
                2'b01:   r_pend <= r_pend - PW'(1);
                default: r_pend <= r_pend;
            endcase
        end
    end

    dcw_profile #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .VW         (VW),
        .XW         (XW),
        .YW         (YW)
    ) u_prof (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel       (i_pix.pixel),
        .i_frame_start (i_pix.frame_start),
        .i_width       (w_eff),
        .i_height      (h_eff),
        .i_threshold   (r_black_thr),
        .i_margin      (VW'(r_margin)),
        .i_row_min     (VW'(r_row_min)),
        .i_col_min     (VW'(r_col_min)),
        .o_frame_end   (frame_end),
        .o_judge       (judge),
        .o_x           (judge_x),
        .o_y           (judge_y),
        .o_init_w      (init_w),
        .o_init_h      (init_h)
    );

    dcw_box #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .VW         (VW),
        .XW         (XW),
        .YW         (YW)
    ) u_box (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_judge     (judge),
        .i_x         (judge_x),
        .i_y         (judge_y),
        .i_init_w    (init_w),
        .i_init_h    (init_h),
        .i_width     (w_eff),
        .i_height    (h_eff),
        .o_res_valid (rep_valid),
        .o_res       (rep)
    );

    dcw_out_q u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rep_valid),
        .i_data  (rep),
        .i_ready (o_res.ready),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // drive the result channel from the queue head
    assign o_res.valid      = q_valid;
    assign o_res.box_found  = q_data.box_found;
    assign o_res.box_left   = q_data.box_left;
    assign o_res.box_right  = q_data.box_right;
    assign o_res.box_top    = q_data.box_top;
    assign o_res.box_bottom = q_data.box_bottom;
    assign o_res.crop_left  = q_data.crop_left;
    assign o_res.crop_top   = q_data.crop_top;
    assign o_res.crop_size  = q_data.crop_size;

endmodule

`default_nettype wire

// ----- src/dcw_chk.sv -----
// Port-level checker for the result channel, bound to the top level.
`default_nettype none

module dcw_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_res_valid,
    input wire logic               i_res_ready,
    input wire logic               i_box_found,
    input wire logic [11:0]        i_box_left,
    input wire logic [10:0]        i_box_right,
    input wire logic [11:0]        i_box_top,
    input wire logic [10:0]        i_box_bottom,
    input wire logic signed [11:0] i_crop_left,
    input wire logic signed [11:0] i_crop_top,
    input wire logic [11:0]        i_crop_size
);

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable({i_box_found, i_box_left,
            i_box_right, i_box_top, i_box_bottom, i_crop_left, i_crop_top, i_crop_size}))
        else $error("result changed while stalled");

    // empty box gives an empty window
    a_empty_crop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_box_found |-> i_crop_size == '0 && i_crop_left == '0
            && i_crop_top == '0)
        else $error("crop window without box");

    // a found box is ordered and gives a nonempty window
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_box_found |-> i_box_left <= {1'b0, i_box_right}
            && i_box_top <= {1'b0, i_box_bottom} && i_crop_size != '0)
        else $error("box edges out of order");

    // the square covers both box extents
    a_crop_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_box_found && i_box_left <= {1'b0, i_box_right}
            && i_box_top <= {1'b0, i_box_bottom}
        |-> i_crop_size > ({1'b0, i_box_right} - i_box_left)
            && i_crop_size > ({1'b0, i_box_bottom} - i_box_top))
        else $error("crop window smaller than box");

endmodule

bind digit_square_crop_window_top dcw_chk u_dcw_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_box_found  (o_res.box_found),
    .i_box_left   (o_res.box_left),
    .i_box_right  (o_res.box_right),
    .i_box_top    (o_res.box_top),
    .i_box_bottom (o_res.box_bottom),
    .i_crop_left  (o_res.crop_left),
    .i_crop_top   (o_res.crop_top),
    .i_crop_size  (o_res.crop_size)
);

`default_nettype wire
